### rtl/iobf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iobf_pkg
// Shared types and constants of the overlap box filter.
// ----------------------------------------------------------------------------
package iobf_pkg;

    localparam int DEF_MAX_BOXES = 64;

    localparam int CMD_W     = 2;
    localparam int POS_W     = 13;
    localparam int COORD_W   = 14;
    localparam int SIZE_W    = 12;
    localparam int REG_W     = 12;
    localparam int REG_IDX_W = 2;
    localparam int EDGE_W    = 15;
    localparam int AREA_W    = 24;
    localparam int CMP_W     = 27;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PRELOAD = 2'd1,
        CMD_FILTER  = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    localparam logic [REG_IDX_W-1:0] REG_ROI_X      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROI_Y      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_WIDTH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIN_HEIGHT = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } box_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } ovl_status_t;

endpackage

### rtl/iou_overlap_box_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_overlap_box_filter
// Box store with intersection-over-union suppression of new detections.
// ----------------------------------------------------------------------------
// Usage: command words enter on the s_ stream (command in s_tuser), one result
// word per command leaves on the m_ stream. A clear word empties the store, a
// preload word appends its box, and a filter word builds a candidate from the
// offset plus region origin and configured window size and appends it only if
// no stored box overlaps it by more than 0.2 IoU. Full stores take no box.
// Timing: clear, preload and unused words go from acceptance straight to the
// result state. A filter word reads the box RAM one entry per cycle through
// the RAM read port into the three-stage overlap pipeline, and the scan ends
// when every entry was read and the pipeline has drained. One word is in work
// at a time; the next word is accepted in the cycle after the result is
// loaded into the output register.
// Stall: a result waits in the output register while m_tready is low; the
// block holds in its result state only if a second result is ready and the
// first has not yet been taken.
// Reset: the store is emptied (count zero) and the registers take their
// defaults: region origin (144, 206), window 64 by 64. No clearing pass is
// needed; only entries below the count are ever read. Configuration must be
// written via cfg_wr_en/cfg_index/cfg_data only while idle; nothing checks it.
// ----------------------------------------------------------------------------
module iou_overlap_box_filter #(
    parameter int MAX_BOXES = iobf_pkg::DEF_MAX_BOXES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [iobf_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [iobf_pkg::REG_W-1:0]        cfg_data,
    // Input words.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: pos_x, pos_y, box_width, box_height, zero fill
    input  logic [iobf_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0: command
    input  logic [iobf_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result words.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: out_x, out_y, out_width, out_height, zero fill
    output logic [iobf_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser fields from bit 0: accepted, store_full
    output logic [iobf_pkg::M_TUSER_W-1:0]    m_tuser
);
    import iobf_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [REG_W-1:0]  roi_x_reg, roi_y_reg, win_w_reg, win_h_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              hit_reg, hit_next;
    logic              v1_reg;
    cmd_t              cmd_reg;
    box_t              box_reg;
    logic [AREA_W-1:0] area2_reg;
    logic              m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    cmd_t              in_cmd;
    logic [POS_W-1:0]  in_px, in_py;
    logic [SIZE_W-1:0] in_w, in_h;
    box_t              in_box;
    logic              in_fire;
    logic              rd_en;
    logic              scan_done;
    logic              out_load;
    logic              keep, has_room, append;
    logic [$bits(box_t)-1:0] ram_rdata;
    ovl_status_t       ovl;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign in_cmd = cmd_t'(s_tuser[CMD_W-1:0]);
    assign in_px  = s_tdata[POS_W-1:0];
    assign in_py  = s_tdata[2*POS_W-1:POS_W];
    assign in_w   = s_tdata[2*POS_W+SIZE_W-1:2*POS_W];
    assign in_h   = s_tdata[2*POS_W+2*SIZE_W-1:2*POS_W+SIZE_W];

    always_comb
    begin
        in_box = '0;
        unique case (in_cmd)
            CMD_PRELOAD:
            begin
                in_box.x = COORD_W'(in_px);
                in_box.y = COORD_W'(in_py);
                in_box.w = in_w;
                in_box.h = in_h;
            end
            CMD_FILTER:
            begin
                in_box.x = COORD_W'(in_px) + COORD_W'(roi_x_reg);
                in_box.y = COORD_W'(in_py) + COORD_W'(roi_y_reg);
                in_box.w = win_w_reg;
                in_box.h = win_h_reg;
            end
            default:
            begin
                in_box = '0;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Scan of the stored boxes: one RAM read per cycle into the overlap
    // pipeline. The scan ends once every entry was read and the pipeline
    // has drained, so the hit flag is final.
    // ------------------------------------------------------------------
    assign rd_en     = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    assign scan_done = (rd_idx_reg >= count_reg) && !v1_reg && !ovl.busy;

    iobf_ram #(
        .WIDTH ($bits(box_t)),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk     (clk),
        .wr_en   (out_load && append),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (box_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    iobf_overlap u_overlap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .stored    (box_t'(ram_rdata)),
        .cand      (box_reg),
        .cand_area (area2_reg),
        .status    (ovl)
    );

    // ------------------------------------------------------------------
    // Result and store update. The store is only written here, after the
    // scan has finished, so reads and writes of one entry never overlap.
    // ------------------------------------------------------------------
    assign out_load = (state_reg == ST_RESULT) && (!m_valid_reg || m_tready);
    assign keep     = (cmd_reg == CMD_PRELOAD) || ((cmd_reg == CMD_FILTER) && !hit_reg);
    assign has_room = (count_reg < CW'(MAX_BOXES));
    assign append   = keep && has_room;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        hit_next     = hit_reg || ovl.hit;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    state_next  = (in_cmd == CMD_FILTER) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (append)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            hit_reg     <= 1'b0;
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            roi_x_reg   <= REG_W'(144);
            roi_y_reg   <= REG_W'(206);
            win_w_reg   <= REG_W'(64);
            win_h_reg   <= REG_W'(64);
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            hit_reg     <= hit_next;
            v1_reg      <= rd_en;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_ROI_X:      roi_x_reg <= cfg_data;
                    REG_ROI_Y:      roi_y_reg <= cfg_data;
                    REG_WIN_WIDTH:  win_w_reg <= cfg_data;
                    REG_WIN_HEIGHT: win_h_reg <= cfg_data;
                    default:        roi_x_reg <= roi_x_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= in_cmd;
            box_reg   <= in_box;
            area2_reg <= AREA_W'(win_w_reg) * AREA_W'(win_h_reg);
        end
        if (out_load)
        begin
            m_data_reg <= {(M_TDATA_W - $bits(box_t))'(0),
                           box_reg.h, box_reg.w, box_reg.y, box_reg.x};
            m_user_reg <= {keep && !has_room, append};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BOXES))
        else $error("box count exceeds store depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both accepted and dropped");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && append) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("append did not advance the box count");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (cmd_reg == CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the store");

    a_scan_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> !rd_en)
        else $error("store read outside of a scan");

endmodule

### rtl/iobf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iobf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iobf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/iobf_overlap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iobf_overlap
// Pipelined overlap test of one stored box against the candidate per cycle.
// ----------------------------------------------------------------------------
module iobf_overlap (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  iobf_pkg::box_t               stored,
    input  iobf_pkg::box_t               cand,
    input  logic [iobf_pkg::AREA_W-1:0]  cand_area,
    output iobf_pkg::ovl_status_t        status
);
    import iobf_pkg::*;

    logic [EDGE_W-1:0] a_right, a_bottom, b_right, b_bottom;
    logic [EDGE_W-1:0] right, bottom, left, top;
    logic              disjoint;
    logic [SIZE_W-1:0] iw, ih;

    logic              va_reg;
    logic [SIZE_W-1:0] iw_reg, ih_reg, aw_reg, ah_reg;
    logic              vb_reg;
    logic [AREA_W-1:0] inter_reg, area1_reg;
    logic [CMP_W-1:0]  lhs, rhs;

    // Stage one: edges of the intersection. Disjoint boxes give zero width.
    always_comb
    begin
        a_right  = EDGE_W'(stored.x) + EDGE_W'(stored.w);
        a_bottom = EDGE_W'(stored.y) + EDGE_W'(stored.h);
        b_right  = EDGE_W'(cand.x) + EDGE_W'(cand.w);
        b_bottom = EDGE_W'(cand.y) + EDGE_W'(cand.h);
        disjoint = (EDGE_W'(stored.x) > b_right) || (EDGE_W'(stored.y) > b_bottom)
                || (a_right < EDGE_W'(cand.x)) || (a_bottom < EDGE_W'(cand.y));
        right    = (a_right < b_right) ? a_right : b_right;
        bottom   = (a_bottom < b_bottom) ? a_bottom : b_bottom;
        left     = (stored.x > cand.x) ? EDGE_W'(stored.x) : EDGE_W'(cand.x);
        top      = (stored.y > cand.y) ? EDGE_W'(stored.y) : EDGE_W'(cand.y);
        iw       = disjoint ? '0 : SIZE_W'(right - left);
        ih       = disjoint ? '0 : SIZE_W'(bottom - top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        iw_reg    <= iw;
        ih_reg    <= ih;
        aw_reg    <= stored.w;
        ah_reg    <= stored.h;
        // Stage two: intersection area and stored box area.
        inter_reg <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
        area1_reg <= AREA_W'(aw_reg) * AREA_W'(ah_reg);
    end

    // Stage three: IoU above one fifth, written as 6*inter > area1 + area2.
    always_comb
    begin
        lhs         = (CMP_W'(inter_reg) << 2) + (CMP_W'(inter_reg) << 1);
        rhs         = CMP_W'(area1_reg) + CMP_W'(cand_area);
        status.hit  = vb_reg && (lhs > rhs);
        status.busy = va_reg || vb_reg;
    end

endmodule
